// ----- rtl/core/sote_pkg.sv -----
// shared types and constants for the synchronization object table engine
// no dependencies; used by every module of the block but sote_ram, by scoped names
package sote_pkg;

    localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;

    // request codes
    typedef enum logic [3:0] {
        REQ_CREATE_SEM   = 4'd0,
        REQ_CREATE_MUTEX = 4'd1,
        REQ_CREATE_EVENT = 4'd2,
        REQ_SEM_RELEASE  = 4'd3,
        REQ_SEM_READ     = 4'd4,
        REQ_MUTEX_UNLOCK = 4'd5,
        REQ_MUTEX_KILL   = 4'd6,
        REQ_MUTEX_READ   = 4'd7,
        REQ_EVENT_SET    = 4'd8,
        REQ_EVENT_RESET  = 4'd9,
        REQ_EVENT_PULSE  = 4'd10,
        REQ_EVENT_READ   = 4'd11,
        REQ_TRY_ACQUIRE  = 4'd12
    } t_req_code;

    // result status codes
    typedef enum logic [2:0] {
        STAT_OK           = 3'd0,
        STAT_INVALID      = 3'd1,
        STAT_OVERFLOW     = 3'd2,
        STAT_NOT_OWNER    = 3'd3,
        STAT_OWNER_DEAD   = 3'd4,
        STAT_NOT_ACQUIRED = 3'd5,
        STAT_UNSUPPORTED  = 3'd6
    } t_status;

    // object kinds held in a table entry
    typedef enum logic [1:0] {
        KIND_SEM   = 2'd0,
        KIND_MUTEX = 2'd1,
        KIND_EVENT = 2'd2
    } t_kind;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [5:0]  obj_index;
        logic [31:0] owner_id;
        logic [31:0] arg_count;
        logic [31:0] arg_max;
        logic        manual_flag;
        logic        signaled_flag;
    } t_req_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value_a;
        logic [31:0] value_b;
    } t_rsp_item;

    // one table entry as stored in the ram
    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic        abandoned;
        logic [31:0] word_a;
        logic [31:0] word_b;
    } t_entry;

    typedef enum logic [1:0] {
        CTL_CLEAR,
        CTL_IDLE,
        CTL_EXEC
    } t_ctl_state;

    // controller to datapath
    typedef struct packed {
        logic clr_write;
        logic accept;
        logic exec;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic rsp_free;
    } t_dp_status;

endpackage

// ----- rtl/core/sote_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module sote_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/sote_ctrl.sv -----
// control state machine: clearing pass, request accept, execute
// depends on sote_pkg
module sote_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_stall,
    input  sote_pkg::t_dp_status i_status,
    output sote_pkg::t_dp_cmd   o_cmd
);

    sote_pkg::t_ctl_state r_state;
    sote_pkg::t_ctl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sote_pkg::CTL_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_stall = 1'b1;
        case (r_state)
            sote_pkg::CTL_CLEAR: begin
                o_cmd.clr_write = 1'b1;
                if (i_status.clr_last) begin
                    n_state = sote_pkg::CTL_IDLE;
                end
            end
            sote_pkg::CTL_IDLE: begin
                o_req_stall = 1'b0;
                if (i_req_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = sote_pkg::CTL_EXEC;
                end
            end
            sote_pkg::CTL_EXEC: begin
                // wait here while the previous result still sits unclaimed
                if (i_status.rsp_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = sote_pkg::CTL_IDLE;
                end
            end
            default: begin
                n_state = sote_pkg::CTL_CLEAR;
            end
        endcase
    end

endmodule

// ----- rtl/core/sote_datapath.sv -----
// request register, object table ram, operation logic and result register
// depends on sote_pkg and sote_ram
module sote_datapath #(
    parameter int NUM_OBJECTS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sote_pkg::t_dp_cmd     i_cmd,
    output sote_pkg::t_dp_status  o_status,
    input  sote_pkg::t_req_item   i_req,
    output logic                  o_rsp_valid,
    input  logic                  i_rsp_stall,
    output sote_pkg::t_rsp_item   o_rsp
);

    localparam int AW = $clog2(NUM_OBJECTS);
    localparam int EW = $bits(sote_pkg::t_entry);

    sote_pkg::t_req_item r_req;
    sote_pkg::t_rsp_item r_rsp;
    logic                r_rsp_valid;
    logic [AW-1:0]       r_clr_idx;

    logic [EW-1:0]       ram_rdata;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [EW-1:0]       ram_wdata;

    sote_pkg::t_entry    cur;
    sote_pkg::t_entry    upd;
    sote_pkg::t_rsp_item res;
    logic                upd_we;
    logic                in_range;

    sote_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_OBJECTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (AW'(i_req.obj_index)),
        .o_rdata (ram_rdata)
    );

    assign cur = sote_pkg::t_entry'(ram_rdata);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_req;
        end
        if (i_cmd.exec) begin
            r_rsp <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
            r_clr_idx   <= '0;
        end else begin
            if (i_cmd.exec) begin
                r_rsp_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
            if (i_cmd.clr_write) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    assign o_status.clr_last = (r_clr_idx == AW'(NUM_OBJECTS - 1));
    assign o_status.rsp_free = !r_rsp_valid || !i_rsp_stall;

    assign in_range = (32'(r_req.obj_index) < NUM_OBJECTS);

    // operation logic on the entry read at accept
    always_comb begin
        upd    = cur;
        upd_we = 1'b0;
        res    = '0;
        res.status = sote_pkg::STAT_OK;
        case (r_req.req_type)
            sote_pkg::REQ_CREATE_SEM, sote_pkg::REQ_CREATE_MUTEX,
            sote_pkg::REQ_CREATE_EVENT, sote_pkg::REQ_SEM_RELEASE,
            sote_pkg::REQ_SEM_READ, sote_pkg::REQ_MUTEX_UNLOCK,
            sote_pkg::REQ_MUTEX_KILL, sote_pkg::REQ_MUTEX_READ,
            sote_pkg::REQ_EVENT_SET, sote_pkg::REQ_EVENT_RESET,
            sote_pkg::REQ_EVENT_PULSE, sote_pkg::REQ_EVENT_READ,
            sote_pkg::REQ_TRY_ACQUIRE: begin
                if (!in_range) begin
                    res.status = sote_pkg::STAT_INVALID;
                end else begin
                    case (r_req.req_type)
                        sote_pkg::REQ_CREATE_SEM: begin
                            if (r_req.arg_count > r_req.arg_max) begin
                                res.status = sote_pkg::STAT_INVALID;
                            end else begin
                                upd_we        = 1'b1;
                                upd.valid     = 1'b1;
                                upd.kind      = sote_pkg::KIND_SEM;
                                upd.abandoned = 1'b0;
                                upd.word_a    = r_req.arg_count;
                                upd.word_b    = r_req.arg_max;
                            end
                        end
                        sote_pkg::REQ_CREATE_MUTEX: begin
                            if ((r_req.owner_id == '0) != (r_req.arg_count == '0)) begin
                                res.status = sote_pkg::STAT_INVALID;
                            end else begin
                                upd_we        = 1'b1;
                                upd.valid     = 1'b1;
                                upd.kind      = sote_pkg::KIND_MUTEX;
                                upd.abandoned = 1'b0;
                                upd.word_a    = r_req.arg_count;
                                upd.word_b    = r_req.owner_id;
                            end
                        end
                        sote_pkg::REQ_CREATE_EVENT: begin
                            upd_we        = 1'b1;
                            upd.valid     = 1'b1;
                            upd.kind      = sote_pkg::KIND_EVENT;
                            upd.abandoned = 1'b0;
                            upd.word_a    = 32'(r_req.signaled_flag);
                            upd.word_b    = 32'(r_req.manual_flag);
                        end
                        default: begin
                            if (!cur.valid) begin
                                res.status = sote_pkg::STAT_INVALID;
                            end else begin
                                case (r_req.req_type)
                                    sote_pkg::REQ_TRY_ACQUIRE: begin
                                        res.value_a = cur.word_a;
                                        case (cur.kind)
                                            sote_pkg::KIND_SEM: begin
                                                if (cur.word_a != '0) begin
                                                    upd_we     = 1'b1;
                                                    upd.word_a = cur.word_a - 32'd1;
                                                end else begin
                                                    res.status = sote_pkg::STAT_NOT_ACQUIRED;
                                                end
                                            end
                                            sote_pkg::KIND_MUTEX: begin
                                                if ((cur.word_b == '0 ||
                                                     cur.word_b == r_req.owner_id) &&
                                                    cur.word_a != sote_pkg::ALL_ONES32) begin
                                                    if (cur.abandoned) begin
                                                        res.status = sote_pkg::STAT_OWNER_DEAD;
                                                    end
                                                    upd_we        = 1'b1;
                                                    upd.abandoned = 1'b0;
                                                    upd.word_a    = cur.word_a + 32'd1;
                                                    upd.word_b    = r_req.owner_id;
                                                end else begin
                                                    res.status = sote_pkg::STAT_NOT_ACQUIRED;
                                                end
                                            end
                                            sote_pkg::KIND_EVENT: begin
                                                if (cur.word_a != '0) begin
                                                    // auto reset consumes the signal
                                                    if (cur.word_b == '0) begin
                                                        upd_we     = 1'b1;
                                                        upd.word_a = '0;
                                                    end
                                                end else begin
                                                    res.status = sote_pkg::STAT_NOT_ACQUIRED;
                                                end
                                            end
                                            default: begin
                                                res.status  = sote_pkg::STAT_INVALID;
                                                res.value_a = '0;
                                            end
                                        endcase
                                    end
                                    sote_pkg::REQ_SEM_RELEASE, sote_pkg::REQ_SEM_READ: begin
                                        if (cur.kind != sote_pkg::KIND_SEM) begin
                                            res.status = sote_pkg::STAT_INVALID;
                                        end else if (r_req.req_type == sote_pkg::REQ_SEM_READ) begin
                                            res.value_a = cur.word_a;
                                            res.value_b = cur.word_b;
                                        end else if (cur.word_a > cur.word_b ||
                                                     r_req.arg_count > cur.word_b - cur.word_a) begin
                                            res.status = sote_pkg::STAT_OVERFLOW;
                                        end else begin
                                            upd_we      = 1'b1;
                                            upd.word_a  = cur.word_a + r_req.arg_count;
                                            res.value_a = cur.word_a;
                                        end
                                    end
                                    sote_pkg::REQ_MUTEX_UNLOCK, sote_pkg::REQ_MUTEX_KILL,
                                    sote_pkg::REQ_MUTEX_READ: begin
                                        if (cur.kind != sote_pkg::KIND_MUTEX) begin
                                            res.status = sote_pkg::STAT_INVALID;
                                        end else if (r_req.req_type == sote_pkg::REQ_MUTEX_READ) begin
                                            if (cur.abandoned) begin
                                                res.status = sote_pkg::STAT_OWNER_DEAD;
                                            end else begin
                                                res.value_a = cur.word_a;
                                                res.value_b = cur.word_b;
                                            end
                                        end else if (r_req.owner_id == '0) begin
                                            res.status = sote_pkg::STAT_INVALID;
                                        end else if (cur.word_b != r_req.owner_id) begin
                                            res.status = sote_pkg::STAT_NOT_OWNER;
                                        end else if (r_req.req_type == sote_pkg::REQ_MUTEX_UNLOCK) begin
                                            if (cur.word_a == '0) begin
                                                res.status = sote_pkg::STAT_INVALID;
                                            end else begin
                                                upd_we      = 1'b1;
                                                upd.word_a  = cur.word_a - 32'd1;
                                                if (cur.word_a == 32'd1) begin
                                                    upd.word_b = '0;
                                                end
                                                res.value_a = cur.word_a;
                                            end
                                        end else begin
                                            upd_we        = 1'b1;
                                            upd.word_a    = '0;
                                            upd.word_b    = '0;
                                            upd.abandoned = 1'b1;
                                        end
                                    end
                                    default: begin
                                        // event set, reset, pulse and read
                                        if (cur.kind != sote_pkg::KIND_EVENT) begin
                                            res.status = sote_pkg::STAT_INVALID;
                                        end else if (r_req.req_type == sote_pkg::REQ_EVENT_READ) begin
                                            res.value_a = cur.word_a;
                                            res.value_b = cur.word_b;
                                        end else begin
                                            upd_we      = 1'b1;
                                            upd.word_a  = 32'(r_req.req_type == sote_pkg::REQ_EVENT_SET);
                                            res.value_a = cur.word_a;
                                        end
                                    end
                                endcase
                            end
                        end
                    endcase
                end
            end
            default: begin
                res.status = sote_pkg::STAT_UNSUPPORTED;
            end
        endcase
    end

    // the clearing pass and request write-back share the single write port
    always_comb begin
        if (i_cmd.clr_write) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_idx;
            ram_wdata = '0;
        end else begin
            ram_we    = i_cmd.exec && upd_we;
            ram_waddr = AW'(r_req.obj_index);
            ram_wdata = upd;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

// ----- rtl/core/sync_object_table_engine_unit.sv -----
// top level of the synchronization object table engine
// depends on sote_pkg, sote_ctrl, sote_datapath and sote_ram
//
// a table of NUM_OBJECTS synchronization objects (counting semaphores,
// recursive owned mutexes with an abandoned mark, auto or manual reset
// events) kept in one ram word per entry. each request item names an
// entry and an operation and returns exactly one result item: status and
// two values. the accept edge reads the entry from the table ram
// (registered read), and the execute step that follows does the
// operation, writes the entry back and loads the result register; a new
// request is taken only once the execute step of the last one is done.
// the result register lets a new request be taken while an earlier
// result still waits; a request whose result cannot be stored yet holds
// in the execute step. after reset the block clears the valid mark of
// every entry, one entry a cycle, and stalls requests until that pass
// is done.
module sync_object_table_engine_unit #(
    parameter int NUM_OBJECTS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_req_valid,
    output logic                o_req_stall,
    input  sote_pkg::t_req_item i_req,
    // result channel
    output logic                o_rsp_valid,
    input  logic                i_rsp_stall,
    output sote_pkg::t_rsp_item o_rsp
);

    // command and status between sequencer and datapath
    sote_pkg::t_dp_cmd    dp_cmd;
    sote_pkg::t_dp_status dp_status;

    sote_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // entry table, operation logic and result register
    sote_datapath #(
        .NUM_OBJECTS (NUM_OBJECTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

endmodule

// ----- tb/sote_result_checker.sv -----
// result checker for the synchronization object table engine
// watches both item channels, predicts each result from its own object table
// depends on sote_pkg
module sote_result_checker #(
    parameter int NUM_OBJECTS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  logic                i_req_stall,
    input  sote_pkg::t_req_item i_req,
    input  logic                i_rsp_valid,
    input  logic                i_rsp_stall,
    input  sote_pkg::t_rsp_item i_rsp,
    output int unsigned         o_fail_count,
    output int unsigned         o_pending
);
    import sote_pkg::*;

    // predicted object table
    bit          obj_valid     [NUM_OBJECTS];
    t_kind       obj_kind      [NUM_OBJECTS];
    logic [31:0] obj_word_a    [NUM_OBJECTS];
    logic [31:0] obj_word_b    [NUM_OBJECTS];
    bit          obj_abandoned [NUM_OBJECTS];

    t_rsp_item   expected_results [$];
    int unsigned fail_total;

    function automatic void store_object(input logic [5:0] ix, input t_kind kind,
                                         input logic [31:0] wa, input logic [31:0] wb);
        obj_valid[ix]     = 1'b1;
        obj_kind[ix]      = kind;
        obj_word_a[ix]    = wa;
        obj_word_b[ix]    = wb;
        obj_abandoned[ix] = 1'b0;
    endfunction

    // applies one request to the predicted table and returns its result
    function automatic t_rsp_item predict_result(input t_req_item rq);
        t_rsp_item   r;
        logic [5:0]  ix;
        logic [31:0] a;
        logic [31:0] b;
        r        = '0;
        r.status = STAT_OK;
        ix       = rq.obj_index;
        if (rq.req_type > REQ_TRY_ACQUIRE) begin
            r.status = STAT_UNSUPPORTED;
            return r;
        end
        if (ix >= NUM_OBJECTS) begin
            r.status = STAT_INVALID;
            return r;
        end
        case (rq.req_type)
            REQ_CREATE_SEM: begin
                if (rq.arg_count > rq.arg_max) r.status = STAT_INVALID;
                else store_object(ix, KIND_SEM, rq.arg_count, rq.arg_max);
                return r;
            end
            REQ_CREATE_MUTEX: begin
                if ((rq.owner_id == '0) != (rq.arg_count == '0)) r.status = STAT_INVALID;
                else store_object(ix, KIND_MUTEX, rq.arg_count, rq.owner_id);
                return r;
            end
            REQ_CREATE_EVENT: begin
                store_object(ix, KIND_EVENT, {31'b0, rq.signaled_flag}, {31'b0, rq.manual_flag});
                return r;
            end
            default: ;
        endcase
        if (!obj_valid[ix]) begin
            r.status = STAT_INVALID;
            return r;
        end
        a = obj_word_a[ix];
        b = obj_word_b[ix];
        case (rq.req_type)
            REQ_TRY_ACQUIRE: begin
                case (obj_kind[ix])
                    KIND_SEM: begin
                        r.value_a = a;
                        if (a != '0) obj_word_a[ix] = a - 32'd1;
                        else r.status = STAT_NOT_ACQUIRED;
                    end
                    KIND_MUTEX: begin
                        r.value_a = a;
                        if ((b == '0 || b == rq.owner_id) && a != ALL_ONES32) begin
                            r.status = obj_abandoned[ix] ? STAT_OWNER_DEAD : STAT_OK;
                            obj_abandoned[ix] = 1'b0;
                            obj_word_a[ix]    = a + 32'd1;
                            obj_word_b[ix]    = rq.owner_id;
                        end else begin
                            r.status = STAT_NOT_ACQUIRED;
                        end
                    end
                    KIND_EVENT: begin
                        r.value_a = a;
                        if (a != '0) begin
                            // auto reset event is consumed
                            if (b == '0) obj_word_a[ix] = '0;
                        end else begin
                            r.status = STAT_NOT_ACQUIRED;
                        end
                    end
                    default: r.status = STAT_INVALID;
                endcase
            end
            REQ_SEM_RELEASE, REQ_SEM_READ: begin
                if (obj_kind[ix] != KIND_SEM) begin
                    r.status = STAT_INVALID;
                end else if (rq.req_type == REQ_SEM_READ) begin
                    r.value_a = a;
                    r.value_b = b;
                end else if (a > b || rq.arg_count > b - a) begin
                    r.status = STAT_OVERFLOW;
                end else begin
                    obj_word_a[ix] = a + rq.arg_count;
                    r.value_a      = a;
                end
            end
            REQ_MUTEX_UNLOCK, REQ_MUTEX_KILL, REQ_MUTEX_READ: begin
                if (obj_kind[ix] != KIND_MUTEX) begin
                    r.status = STAT_INVALID;
                end else if (rq.req_type == REQ_MUTEX_READ) begin
                    if (obj_abandoned[ix]) begin
                        r.status = STAT_OWNER_DEAD;
                    end else begin
                        r.value_a = a;
                        r.value_b = b;
                    end
                end else if (rq.owner_id == '0) begin
                    r.status = STAT_INVALID;
                end else if (b != rq.owner_id) begin
                    r.status = STAT_NOT_OWNER;
                end else if (rq.req_type == REQ_MUTEX_UNLOCK) begin
                    if (a == '0) begin
                        r.status = STAT_INVALID;
                    end else begin
                        obj_word_a[ix] = a - 32'd1;
                        if (a == 32'd1) obj_word_b[ix] = '0;
                        r.value_a = a;
                    end
                end else begin
                    obj_word_a[ix]    = '0;
                    obj_word_b[ix]    = '0;
                    obj_abandoned[ix] = 1'b1;
                end
            end
            default: begin
                // event set, reset, pulse, read
                if (obj_kind[ix] != KIND_EVENT) begin
                    r.status = STAT_INVALID;
                end else if (rq.req_type == REQ_EVENT_READ) begin
                    r.value_a = a;
                    r.value_b = b;
                end else begin
                    obj_word_a[ix] = (rq.req_type == REQ_EVENT_SET) ? 32'd1 : 32'd0;
                    r.value_a      = a;
                end
            end
        endcase
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want_v,
                                          input logic [31:0] got_v);
        if (got_v !== want_v) begin
            fail_total++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
        end
    endfunction

    always @(posedge i_clk) begin
        t_rsp_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_OBJECTS; i++) begin
                obj_valid[i]     = 1'b0;
                obj_kind[i]      = KIND_SEM;
                obj_word_a[i]    = '0;
                obj_word_b[i]    = '0;
                obj_abandoned[i] = 1'b0;
            end
            expected_results.delete();
            fail_total = 0;
        end else begin
            // result first: it can never belong to a request taken at this edge
            if (i_rsp_valid && !i_rsp_stall) begin
                if (expected_results.size() == 0) begin
                    fail_total++;
                    $display("%0t: result with none expected, expected nothing, actual %h",
                             $time, i_rsp);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("status", 32'(want.status), 32'(i_rsp.status));
                    compare_field("value_a", want.value_a, i_rsp.value_a);
                    compare_field("value_b", want.value_b, i_rsp.value_b);
                end
            end
            if (i_req_valid && !i_req_stall)
                expected_results.push_back(predict_result(i_req));
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_results.size();
    end

endmodule

// ----- tb/tb.sv -----
// testbench top for sync_object_table_engine_unit
// drives request items and result back-pressure; sote_result_checker does the checking
// depends on sote_pkg, sote_result_checker and the block itself
module tb;
    import sote_pkg::*;

    localparam int          NUM_OBJECTS      = 64;
    localparam int unsigned RANDOM_ITEMS     = 550;
    localparam int unsigned QUIET_ITEMS      = 100;  // last part runs with no idling
    localparam int unsigned LONG_HOLD_AT     = 120;  // random item that starts the long hold
    localparam int unsigned LONG_HOLD_CYCLES = 200;
    localparam int unsigned SETTLE_CYCLES    = 10;
    localparam int unsigned CYCLE_LIMIT      = 200_000;

    // request codes the block does not support
    localparam logic [3:0] REQ_UNUSED_LO = 4'd13;
    localparam logic [3:0] REQ_UNUSED_HI = 4'd15;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    t_req_item req_item  = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    t_rsp_item rsp_item;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned cycle_count;

    // phase flags shared by the sender and the receiver
    bit quiet;
    bit long_hold_due;

    // what the stimulus last tried to create at each entry, to steer ops to the right kind
    bit    shadow_made [NUM_OBJECTS];
    t_kind shadow_kind [NUM_OBJECTS];

    initial forever #5 clk = ~clk;

    sync_object_table_engine_unit #(
        .NUM_OBJECTS(NUM_OBJECTS)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_stall (req_stall),
        .i_req       (req_item),
        .o_rsp_valid (rsp_valid),
        .i_rsp_stall (rsp_stall),
        .o_rsp       (rsp_item)
    );

    sote_result_checker #(
        .NUM_OBJECTS(NUM_OBJECTS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_stall  (req_stall),
        .i_req        (req_item),
        .i_rsp_valid  (rsp_valid),
        .i_rsp_stall  (rsp_stall),
        .i_rsp        (rsp_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // ---------------------------------------------------------------
    // item builders
    // ---------------------------------------------------------------

    function automatic t_req_item make_item(input logic [3:0] op, input logic [5:0] ix,
                                            input logic [31:0] own, input logic [31:0] cnt,
                                            input logic [31:0] mx, input bit man,
                                            input bit sig);
        t_req_item it;
        it.req_type      = op;
        it.obj_index     = ix;
        it.owner_id      = own;
        it.arg_count     = cnt;
        it.arg_max       = mx;
        it.manual_flag   = man;
        it.signaled_flag = sig;
        return it;
    endfunction

    // owners mostly from a small pool so that unlocks and re-acquires match
    function automatic logic [31:0] pick_owner();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return $urandom();
            default: return 32'($urandom_range(1, 3));
        endcase
    endfunction

    // counts and release amounts mostly small, now and then anything
    function automatic logic [31:0] pick_amount();
        if ($urandom_range(0, 9) == 0) return $urandom();
        return 32'($urandom_range(0, 3));
    endfunction

    // mostly well-formed: creates followed by ops that fit the kind,
    // with some wrong-kind ops, unused codes and pure noise mixed in
    function automatic t_req_item random_request();
        t_req_item   it;
        int unsigned dice;
        int unsigned pick;
        logic [5:0]  ix;
        t_kind       kind;
        ix   = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 7)) : 6'($urandom());
        dice = $urandom_range(0, 99);
        pick = $urandom_range(0, 99);
        it   = make_item(REQ_SEM_READ, ix, pick_owner(), pick_amount(),
                         32'($urandom_range(0, 6)), 1'($urandom()), 1'($urandom()));
        if (dice < 3) begin
            // noise, every bit random
            it = {4'($urandom()), 6'($urandom()), $urandom(), $urandom(), $urandom(),
                  2'($urandom())};
        end else if (dice < 6) begin
            it.req_type = 4'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
        end else if (dice < 20 || (!shadow_made[ix] && dice < 60)) begin
            kind = t_kind'($urandom_range(KIND_SEM, KIND_EVENT));
            case (kind)
                KIND_SEM: begin
                    it.req_type = REQ_CREATE_SEM;
                    if (pick < 15) begin
                        // near the top, for release overflow
                        it.arg_max   = ALL_ONES32 - 32'($urandom_range(0, 3));
                        it.arg_count = it.arg_max - 32'($urandom_range(0, 4));
                    end else if (pick < 25) begin
                        it.arg_max   = $urandom();
                        it.arg_count = $urandom();
                    end
                end
                KIND_MUTEX: begin
                    it.req_type = REQ_CREATE_MUTEX;
                    if (pick < 60) begin
                        it.owner_id  = '0;
                        it.arg_count = '0;
                    end else if (pick < 85) begin
                        it.owner_id  = 32'($urandom_range(1, 3));
                        it.arg_count = 32'($urandom_range(1, 2));
                    end else if (pick < 92) begin
                        // one below saturation of the recursion count
                        it.owner_id  = 32'($urandom_range(1, 3));
                        it.arg_count = ALL_ONES32 - 32'd1;
                    end
                end
                default: it.req_type = REQ_CREATE_EVENT;
            endcase
            shadow_made[ix] = 1'b1;
            shadow_kind[ix] = kind;
        end else if (!shadow_made[ix] || pick < 10) begin
            // any op, possibly on the wrong kind or an empty entry
            it.req_type = 4'($urandom_range(REQ_SEM_RELEASE, REQ_TRY_ACQUIRE));
        end else begin
            case (shadow_kind[ix])
                KIND_SEM:
                    it.req_type = (pick < 50) ? REQ_SEM_RELEASE :
                                  (pick < 65) ? REQ_SEM_READ : REQ_TRY_ACQUIRE;
                KIND_MUTEX:
                    it.req_type = (pick < 50) ? REQ_TRY_ACQUIRE :
                                  (pick < 80) ? REQ_MUTEX_UNLOCK :
                                  (pick < 92) ? REQ_MUTEX_READ : REQ_MUTEX_KILL;
                default:
                    it.req_type = (pick < 35) ? REQ_TRY_ACQUIRE :
                                  (pick < 52) ? REQ_EVENT_SET :
                                  (pick < 66) ? REQ_EVENT_RESET :
                                  (pick < 80) ? REQ_EVENT_PULSE : REQ_EVENT_READ;
            endcase
        end
        return it;
    endfunction

    // ---------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------

    // random idle burst, skipped in the quiet part
    task automatic pause_sender();
        if (!quiet && $urandom_range(0, 2) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
    endtask

    // offer one item at a falling edge and hold it until accepted
    task automatic send_item(input t_req_item it);
        req_item  <= it;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        @(negedge clk);
        pause_sender();
    endtask

    // stop offering until every expected result has come back
    task automatic drain_results();
        req_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // extremes and every special case, in an order where each sets up the next
    task automatic run_directed();
        // empty entry, unused code with all fields at their top
        send_item(make_item(REQ_SEM_READ, 6'd5, '0, '0, '0, 1'b0, 1'b0));
        send_item(make_item(REQ_UNUSED_HI, 6'd63, ALL_ONES32, ALL_ONES32, ALL_ONES32,
                            1'b1, 1'b1));
        // semaphore: bad create, empty, fill to the top, overflow, take
        send_item(make_item(REQ_CREATE_SEM, 6'd0, '0, 32'd5, 32'd3, 1'b0, 1'b0));
        send_item(make_item(REQ_CREATE_SEM, 6'd0, '0, '0, ALL_ONES32, 1'b0, 1'b0));
        send_item(make_item(REQ_TRY_ACQUIRE, 6'd0, '0, '0, '0, 1'b0, 1'b0));
        send_item(make_item(REQ_SEM_RELEASE, 6'd0, '0, ALL_ONES32, '0, 1'b0, 1'b0));
        send_item(make_item(REQ_SEM_RELEASE, 6'd0, '0, 32'd1, '0, 1'b0, 1'b0));
        send_item(make_item(REQ_TRY_ACQUIRE, 6'd0, '0, '0, '0, 1'b0, 1'b0));
        // mutex op on a semaphore
        send_item(make_item(REQ_MUTEX_UNLOCK, 6'd0, 32'd1, '0, '0, 1'b0, 1'b0));
        // mutex: bad create, saturated recursion, ownership errors, abandon and recover
        send_item(make_item(REQ_CREATE_MUTEX, 6'd63, '0, 32'd1, '0, 1'b0, 1'b0));
        send_item(make_item(REQ_CREATE_MUTEX, 6'd63, ALL_ONES32, ALL_ONES32 - 32'd1, '0,
                            1'b0, 1'b0));
        send_item(make_item(REQ_TRY_ACQUIRE, 6'd63, ALL_ONES32, '0, '0, 1'b0, 1'b0));
        send_item(make_item(REQ_TRY_ACQUIRE, 6'd63, ALL_ONES32, '0, '0, 1'b0, 1'b0));
        send_item(make_item(REQ_MUTEX_UNLOCK, 6'd63, '0, '0, '0, 1'b0, 1'b0));
        send_item(make_item(REQ_MUTEX_KILL, 6'd63, 32'd7, '0, '0, 1'b0, 1'b0));
        send_item(make_item(REQ_MUTEX_KILL, 6'd63, ALL_ONES32, '0, '0, 1'b0, 1'b0));
        send_item(make_item(REQ_MUTEX_READ, 6'd63, '0, '0, '0, 1'b0, 1'b0));
        send_item(make_item(REQ_TRY_ACQUIRE, 6'd63, 32'd9, '0, '0, 1'b0, 1'b0));
        send_item(make_item(REQ_MUTEX_UNLOCK, 6'd63, 32'd9, '0, '0, 1'b0, 1'b0));
        // event: manual one over the semaphore entry, then an auto one
        send_item(make_item(REQ_CREATE_EVENT, 6'd0, '0, '0, '0, 1'b1, 1'b1));
        send_item(make_item(REQ_TRY_ACQUIRE, 6'd0, '0, '0, '0, 1'b0, 1'b0));
        send_item(make_item(REQ_EVENT_PULSE, 6'd0, '0, '0, '0, 1'b0, 1'b0));
        send_item(make_item(REQ_CREATE_EVENT, 6'd1, '0, '0, '0, 1'b0, 1'b1));
        send_item(make_item(REQ_TRY_ACQUIRE, 6'd1, '0, '0, '0, 1'b0, 1'b0));
        send_item(make_item(REQ_EVENT_SET, 6'd1, '0, '0, '0, 1'b0, 1'b0));
        send_item(make_item(REQ_EVENT_RESET, 6'd1, '0, '0, '0, 1'b0, 1'b0));
    endtask

    // ---------------------------------------------------------------
    // result side: random stall bursts, one long hold on request
    // ---------------------------------------------------------------

    initial begin
        forever begin
            @(negedge clk);
            if (long_hold_due) begin
                // long hold so the block fills up and stalls its input
                long_hold_due = 1'b0;
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                rsp_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // main sequence and verdict
    // ---------------------------------------------------------------

    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // first requests wait out the clearing pass through the stall
        run_directed();
        drain_results();

        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == LONG_HOLD_AT) long_hold_due = 1'b1;
            // sender pause until the block is empty
            if (n == RANDOM_ITEMS / 2) drain_results();
            if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            send_item(random_request());
        end

        drain_results();
        // room for any stray result after the last one expected
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog, far above the slowest correct run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/sote_pkg.sv
rtl/core/sote_ram.sv
rtl/core/sote_ctrl.sv
rtl/core/sote_datapath.sv
rtl/core/sync_object_table_engine_unit.sv
tb/sote_result_checker.sv
tb/tb.sv
